// ===== src/four_channel_cascade_timer_defines.svh =====
// Assertion macros shared by the checker files of the cascade timer.
// No dependencies; included by the files that assert.
`ifndef FOUR_CHANNEL_CASCADE_TIMER_DEFINES_SVH
`define FOUR_CHANNEL_CASCADE_TIMER_DEFINES_SVH

// Property checked on every rising edge, switched off while reset is asserted.
`define FCT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: timer assertion failed");

// Property checked on every rising edge, reset included.
`define FCT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: timer assertion failed");

`endif

// ===== src/fctmr_pkg.sv =====
// Package of the four-channel cascade timer: widths, codes, item types.
// No dependencies; used by the channel, the top level and the checker.
package fctmr_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int COUNT_W      = 16;
    localparam int PRESCALE_W   = 11;
    localparam int TICKS_W      = PRESCALE_W + 1;
    localparam int SHIFT_W      = 4;
    localparam int READBACKS    = 4;

    localparam logic KIND_CONTROL = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [PRESCALE_W-1:0] t_prescale;

    typedef struct packed {
        logic       kind;
        logic [1:0] channel;
        t_count     reload_value;
        logic       start_bit;
        logic       count_up_bit;
        logic [1:0] prescale_select;
        logic       irq_enable_bit;
    } t_in_item;

    typedef struct packed {
        t_count readback_zero;
        t_count readback_one;
        t_count readback_two;
        t_count readback_three;
    } t_out_item;

    // Control group handed from the top level to one channel.
    typedef struct packed {
        logic       hit;
        t_count     reload;
        logic       start;
        logic       count_up;
        logic [1:0] prescale_sel;
        logic       irq_en;
    } t_chan_ctrl;

    // Prescaler select to shift: divide by 1, 64, 256 or 1024.
    function automatic logic [SHIFT_W-1:0] divider_shift(input logic [1:0] sel);
        logic [SHIFT_W-1:0] sh;
        case (sel)
            2'd0:    sh = SHIFT_W'(0);
            2'd1:    sh = SHIFT_W'(6);
            2'd2:    sh = SHIFT_W'(8);
            2'd3:    sh = SHIFT_W'(10);
            default: sh = SHIFT_W'(0);
        endcase
        return sh;
    endfunction

endpackage

// ===== src/fctmr_stream_if.sv =====
// Valid/ready stream interface that carries one item per transfer.
// The payload type is a parameter; the items come from fctmr_pkg.
interface fctmr_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/fctmr_channel.sv =====
// One timer channel: its state registers and the next-state logic for a
// control or tick transfer. Depends on fctmr_pkg.
module fctmr_channel (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tick,
    input  fctmr_pkg::t_chan_ctrl i_ctrl,
    input  logic                  i_carry,
    output logic                  o_carry,
    output fctmr_pkg::t_count     o_pub_next
);

    logic                              r_running, n_running;
    fctmr_pkg::t_count                 r_count, n_count;
    fctmr_pkg::t_prescale              r_pre, n_pre;
    logic                              r_cascade, n_cascade;
    logic [1:0]                        r_div, n_div;
    logic                              r_irq, n_irq;
    fctmr_pkg::t_count                 r_pub, n_pub;

    logic [fctmr_pkg::TICKS_W-1:0]     w_ticks;
    logic [fctmr_pkg::TICKS_W-1:0]     w_inc;
    logic [fctmr_pkg::TICKS_W-1:0]     w_mask;
    logic [fctmr_pkg::SHIFT_W-1:0]     w_shift;
    logic [fctmr_pkg::COUNT_W:0]       w_sum;

    assign w_shift = fctmr_pkg::divider_shift(r_div);
    assign w_ticks = {1'b0, r_pre} + fctmr_pkg::TICKS_W'(1);
    assign w_inc   = w_ticks >> w_shift;
    assign w_mask  = ~({fctmr_pkg::TICKS_W{1'b1}} << w_shift);
    assign w_sum   = {1'b0, r_count} + (fctmr_pkg::COUNT_W + 1)'(w_inc);

    always_comb begin
        n_running = r_running;
        n_count   = r_count;
        n_pre     = r_pre;
        n_cascade = r_cascade;
        n_div     = r_div;
        n_irq     = r_irq;
        n_pub     = r_pub;
        o_carry   = 1'b0;
        if (i_ctrl.hit) begin
            if (i_ctrl.start) begin
                // A start on a channel that already runs leaves it untouched.
                if (!r_running) begin
                    n_count   = i_ctrl.reload;
                    n_pre     = '0;
                    n_cascade = i_ctrl.count_up;
                    if (!i_ctrl.count_up) begin
                        n_div = i_ctrl.prescale_sel;
                    end
                    n_irq = i_ctrl.irq_en;
                end
                n_running = 1'b1;
            end else begin
                n_running = 1'b0;
            end
        end else if (i_tick && r_running) begin
            if (!r_cascade) begin
                n_count = w_sum[fctmr_pkg::COUNT_W-1:0];
                n_pre   = fctmr_pkg::PRESCALE_W'(w_ticks & w_mask);
                n_pub   = w_sum[fctmr_pkg::COUNT_W-1:0];
                o_carry = w_sum[fctmr_pkg::COUNT_W];
            end else if (i_carry) begin
                // Count-up increment: neither published nor passed on.
                n_count = r_count + fctmr_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_count   <= '0;
            r_pre     <= '0;
            r_cascade <= 1'b0;
            r_div     <= '0;
            r_irq     <= 1'b0;
            r_pub     <= '0;
        end else begin
            r_running <= n_running;
            r_count   <= n_count;
            r_pre     <= n_pre;
            r_cascade <= n_cascade;
            r_div     <= n_div;
            r_irq     <= n_irq;
            r_pub     <= n_pub;
        end
    end

    assign o_pub_next = n_pub;

endmodule

// ===== src/four_channel_cascade_timer.sv =====
// Top level of the cascade timer: channel array, carry chain, result register.
// Depends on fctmr_pkg, fctmr_stream_if and fctmr_channel.

// Takes one transfer per clock cycle: a control item for one channel or a tick
// for all channels, and returns one result per item with the four readback
// counters as they stand after that item, in the next cycle through a single
// output register. All channels update in parallel in the accepting cycle; the path
// is one 16-bit add per channel plus the one-step carry into the next channel.
// A new item is taken whenever the output register is empty or being drained,
// so the rate is one item per cycle while the result side keeps up.
module four_channel_cascade_timer #(
    parameter int CHANNELS = fctmr_pkg::CHANNELS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fctmr_stream_if.sink   i_in_chan,
    fctmr_stream_if.source o_out_chan
);

    logic                     w_accept;
    logic                     w_tick;
    fctmr_pkg::t_count        w_pub [CHANNELS];
    logic                     w_carry [CHANNELS];
    fctmr_pkg::t_count        w_rb [fctmr_pkg::READBACKS];

    logic                     r_out_valid, n_out_valid;
    fctmr_pkg::t_out_item     r_out, n_out;

    assign i_in_chan.ready = !r_out_valid || o_out_chan.ready;
    assign w_accept        = i_in_chan.valid && i_in_chan.ready;
    assign w_tick          = w_accept && (i_in_chan.payload.kind == fctmr_pkg::KIND_TICK);

    for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
        fctmr_pkg::t_chan_ctrl w_ctrl;
        logic                  w_carry_in;

        assign w_ctrl.hit = w_accept
                         && (i_in_chan.payload.kind == fctmr_pkg::KIND_CONTROL)
                         && (int'(i_in_chan.payload.channel) == i);
        assign w_ctrl.reload       = i_in_chan.payload.reload_value;
        assign w_ctrl.start        = i_in_chan.payload.start_bit;
        assign w_ctrl.count_up     = i_in_chan.payload.count_up_bit;
        assign w_ctrl.prescale_sel = i_in_chan.payload.prescale_select;
        assign w_ctrl.irq_en       = i_in_chan.payload.irq_enable_bit;

        if (i == 0) begin : g_first
            assign w_carry_in = 1'b0;
        end else begin : g_next
            assign w_carry_in = w_carry[i-1];
        end

        fctmr_channel u_channel (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tick     (w_tick),
            .i_ctrl     (w_ctrl),
            .i_carry    (w_carry_in),
            .o_carry    (w_carry[i]),
            .o_pub_next (w_pub[i])
        );
    end

    // Readback slots without a channel behind them read zero.
    for (genvar j = 0; j < fctmr_pkg::READBACKS; j++) begin : g_rb
        if (j < CHANNELS) begin : g_live
            assign w_rb[j] = w_pub[j];
        end else begin : g_none
            assign w_rb[j] = '0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (o_out_chan.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_accept) begin
            n_out_valid          = 1'b1;
            n_out.readback_zero  = w_rb[0];
            n_out.readback_one   = w_rb[1];
            n_out.readback_two   = w_rb[2];
            n_out.readback_three = w_rb[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_chan.valid   = r_out_valid;
    assign o_out_chan.payload = r_out;

endmodule

// ===== src/fctmr_checker.sv =====
// Port-level checker for the cascade timer and the bind that attaches it.
// Depends on fctmr_pkg and four_channel_cascade_timer_defines.svh.
`include "four_channel_cascade_timer_defines.svh"

module fctmr_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input fctmr_pkg::t_out_item i_out_payload
);

    logic w_out_stall;

    assign w_out_stall = i_out_valid && !i_out_ready;

    // A result held back by the sink keeps its value.
    `FCT_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_stall |=> i_out_valid && $stable(i_out_payload))

    // Every accepted item shows a result in the next cycle.
    `FCT_ASSERT(a_item_result, i_clk, i_rst_n, i_in_valid && i_in_ready |=> i_out_valid)

    // No item is taken while a result waits with the sink stalled.
    `FCT_ASSERT(a_no_overrun, i_clk, i_rst_n, w_out_stall |-> !i_in_ready)

    // Reset empties the result register.
    `FCT_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind four_channel_cascade_timer fctmr_checker u_fctmr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_chan.valid),
    .i_in_ready    (i_in_chan.ready),
    .i_out_valid   (o_out_chan.valid),
    .i_out_ready   (o_out_chan.ready),
    .i_out_payload (o_out_chan.payload)
);
